// ===== hdl/bus_pkg.sv =====
// bus_pkg: shared types and constants for the bicubic upscale sampler
// no dependencies
package bus_pkg;
   localparam int FracBits = 16;
   localparam int CoordW   = 12;
   localparam int AccW     = 40;

   typedef enum logic [1:0] {
      CSR_SCALE  = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_FETCH,
      ST_FILT,
      ST_DONE
   } state_type;

   typedef enum logic [0:0] {
      ACT_WRITE = 1'b0,
      ACT_READ  = 1'b1
   } action_type;

   // catmull-rom polynomial coefficients from four q16 taps
   typedef struct packed {
      logic signed [AccW-1:0] a;
      logic signed [AccW-1:0] b;
      logic signed [AccW-1:0] c;
      logic signed [AccW-1:0] q1;
   } coef_type;

   // floor of v / 2^sh for signed v (arithmetic shift rounds to minus infinity)
   function automatic logic signed [AccW-1:0] floor_shr(input logic signed [2*AccW-1:0] v,
                                                        input int sh);
      logic signed [2*AccW-1:0] r;
      r = v >>> sh;
      return r[AccW-1:0];
   endfunction
endpackage

// ===== hdl/bicubic_upscale_sampler_core.sv =====
// bicubic_upscale_sampler_core: top level, sample memory and read sequencer
// depends on bus_pkg, bus_div, bus_cubic
// write transfer: accepted while not busy, busy stays low, no result
// read transfer: division of the 28-bit dividend, one bit a cycle, then per column four
//   reads on the single-port sample ram and a filter step, then a cross-column pass;
//   the strobe follows, and the next transfer is taken once the sequencer is idle again
// reset: synchronous, restores scale 2 and 256x256 size; sample memory is not cleared
module bicubic_upscale_sampler_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_SCALE  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [11:0] req_x_coord,
   input  logic [11:0] req_y_coord,
   input  logic [7:0]  req_sample,
   output logic        rsp_valid,
   output logic [7:0]  rsp_pixel_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bus_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int AW = XW + YW;

   // configuration registers (raw) and their effective values
   logic [4:0] scale_ff;
   logic [8:0] width_ff, height_ff;
   logic [6:0] s_eff;
   logic [12:0] w_eff, h_eff;

   always_comb begin
      s_eff = (scale_ff == 5'd0) ? 7'd1 : 7'(scale_ff);
      if (32'(s_eff) > MAX_SCALE) s_eff = 7'(MAX_SCALE);
      w_eff = (width_ff == 9'd0) ? 13'd1 : 13'(width_ff);
      if (32'(w_eff) > MAX_WIDTH) w_eff = 13'(MAX_WIDTH);
      h_eff = (height_ff == 9'd0) ? 13'd1 : 13'(height_ff);
      if (32'(h_eff) > MAX_HEIGHT) h_eff = 13'(MAX_HEIGHT);
   end

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= 5'd2;
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE:  scale_ff  <= csr_data[4:0];
            CSR_WIDTH:  width_ff  <= csr_data[8:0];
            CSR_HEIGHT: height_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // single-port sample memory, registered read
   logic [7:0] mem [2**AW];
   logic [AW-1:0] maddr;
   logic          mwe;
   logic [7:0]    mrd_ff;
   always_ff @(posedge clock) begin
      if (mwe) mem[maddr] <= req_sample;
      mrd_ff <= mem[maddr];
   end

   // request latch
   logic [11:0] cx_ff, cy_ff;
   logic        accept;
   assign accept = start && !busy;
   always_ff @(posedge clock) begin
      if (accept) begin
         cx_ff <= req_x_coord;
         cy_ff <= req_y_coord;
      end
   end

   // two dividers, one per axis
   logic dx_done, dy_done;
   logic [11:0] qx, qy;
   logic [15:0] fx, fy;
   logic div_go;
   assign div_go = accept && req_action == ACT_READ;
   bus_div u_divx (.clock, .reset, .start(div_go), .num(req_x_coord), .den(s_eff),
                   .done(dx_done), .quo(qx), .frac(fx));
   bus_div u_divy (.clock, .reset, .start(div_go), .num(req_y_coord), .den(s_eff),
                   .done(dy_done), .quo(qy), .frac(fy));

   logic [11:0] bx_ff, by_ff;
   logic [15:0] tx_ff, ty_ff;
   always_ff @(posedge clock) begin
      if (dx_done) begin
         bx_ff <= qx;
         tx_ff <= fx;
      end
      if (dy_done) begin
         by_ff <= qy;
         ty_ff <= fy;
      end
   end

   // mirror then clamp an index (base + off - 1) into 0..n-1
   function automatic logic [12:0] edge_idx(input logic [11:0] base, input logic [1:0] off,
                                            input logic [12:0] n);
      logic signed [14:0] i;
      i = $signed({3'b0, base}) + $signed({13'b0, off}) - 15'sd1;
      if (i < 0) i = -i;
      if (i >= $signed({2'b0, n})) i = $signed({1'b0, n, 1'b0}) - i - 15'sd2;
      if (i < 0) i = 15'sd0;
      if (i > $signed({2'b0, n}) - 15'sd1) i = $signed({2'b0, n}) - 15'sd1;
      return i[12:0];
   endfunction

   // sequencer
   state_type st_ff, st_in;
   logic [1:0] col_ff, col_in, row_ff, row_in;
   logic       rd_pend_ff;
   logic [2:0] tapn_ff;
   logic signed [AccW-1:0] q_ff [4];
   logic signed [AccW-1:0] r_ff [4];
   logic       fin_ff;   // final cross-column evaluation running
   logic       cub_go, cub_done;
   coef_type   coef;
   logic signed [AccW-1:0] cub_res;
   logic [15:0] cub_t;
   logic [12:0] px, py;

   always_comb begin
      st_in  = st_ff;
      col_in = col_ff;
      row_in = row_ff;
      unique case (st_ff)
         ST_IDLE:  if (div_go) st_in = ST_DIV;
         ST_DIV:   if (dx_done) begin
            st_in  = ST_FETCH;
            col_in = 2'd0;
            row_in = 2'd0;
         end
         ST_FETCH: if (row_ff == 2'd3) st_in = ST_FILT;
                   else row_in = row_ff + 2'd1;
         ST_FILT:  if (cub_done) begin
            if (fin_ff) st_in = ST_DONE;
            else if (col_ff != 2'd3) begin
               st_in  = ST_FETCH;
               col_in = col_ff + 2'd1;
               row_in = 2'd0;
            end
         end
         ST_DONE:  st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      px    = edge_idx(bx_ff, col_ff, w_eff);
      py    = edge_idx(by_ff, row_ff, h_eff);
      mwe   = accept && req_action == ACT_WRITE
              && {1'b0, req_x_coord} < w_eff && {1'b0, req_y_coord} < h_eff;
      if (mwe) maddr = {req_y_coord[YW-1:0], req_x_coord[XW-1:0]};
      else     maddr = {py[YW-1:0], px[XW-1:0]};
   end

   // tap capture, in the cycle after each read
   logic signed [AccW-1:0] tap_v;
   assign tap_v = $signed({{(AccW-24){1'b0}}, mrd_ff, 16'd0});
   logic fin_go_ff;
   logic signed [AccW-1:0] k0, k1, k2, k3;
   // column results feed the cross-column pass from its start cycle on
   always_comb begin
      if (fin_ff || fin_go_ff) begin
         k0 = r_ff[0]; k1 = r_ff[1]; k2 = r_ff[2]; k3 = r_ff[3];
      end else begin
         k0 = q_ff[0]; k1 = q_ff[1]; k2 = q_ff[2]; k3 = q_ff[3];
      end
   end
   always_comb begin
      coef.a  = k2 - k0;
      coef.b  = (k0 <<< 1) - (k1 <<< 2) - k1 + (k2 <<< 2) - k3;
      coef.c  = (k1 <<< 1) + k1 - (k2 <<< 1) - k2 + k3 - k0;
      coef.q1 = k1;
   end

   assign cub_t  = fin_ff ? tx_ff : ty_ff;
   assign cub_go = (tapn_ff == 3'd4) || fin_go_ff;
   bus_cubic u_cubic (.clock, .reset, .start(cub_go), .coef, .t(cub_t),
                      .done(cub_done), .result(cub_res));

   always_ff @(posedge clock) begin
      if (rd_pend_ff) q_ff[tapn_ff[1:0]] <= tap_v;
      if (cub_done && !fin_ff) r_ff[col_ff] <= cub_res;
      if (reset) begin
         st_ff      <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         tapn_ff    <= '0;
         fin_ff     <= 1'b0;
         fin_go_ff  <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
      end else begin
         st_ff      <= st_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         rd_pend_ff <= st_ff == ST_FETCH;
         if (st_ff == ST_FETCH && row_ff == 2'd0) tapn_ff <= '0;
         else if (rd_pend_ff) tapn_ff <= tapn_ff + 3'd1;
         else if (tapn_ff == 3'd4) tapn_ff <= '0;
         fin_go_ff <= st_ff == ST_FILT && cub_done && col_ff == 2'd3 && !fin_ff;
         if (fin_go_ff) fin_ff <= 1'b1;
         else if (st_ff == ST_DONE) fin_ff <= 1'b0;
      end
   end

   // clamp and truncate the final q16 value
   logic [7:0] pix_ff;
   always_ff @(posedge clock) begin
      if (cub_done && fin_ff) begin
         if (cub_res < 0) pix_ff <= 8'd0;
         else if (cub_res >= $signed(AccW'(255) <<< FracBits)) pix_ff <= 8'd255;
         else pix_ff <= cub_res[FracBits+7:FracBits];
      end
   end

   assign busy            = st_ff != ST_IDLE || dx_done || dy_done;
   assign rsp_valid       = st_ff == ST_DONE;
   assign rsp_pixel_value = pix_ff;
endmodule

// ===== hdl/bus_div.sv =====
// bus_div: restoring divider for coord div/mod scale and the q0.16 fraction
// depends on bus_pkg
module bus_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bus_pkg::CoordW-1:0] num,
   input  logic [6:0]                den,
   output logic                      done,
   output logic [bus_pkg::CoordW-1:0] quo,
   output logic [15:0]               frac
);
   import bus_pkg::*;
   // dividend is num followed by 16 zero bits: quotient high part = div, low = fraction
   localparam int NW = CoordW + FracBits;
   logic [NW-1:0] q_ff, q_in;
   logic [7:0]    r_ff, r_in;
   logic [4:0]    n_ff, n_in;
   logic          busy_ff, busy_in;
   logic [8:0]    trial;

   always_comb begin
      trial   = {r_ff, q_ff[NW-1]} - {2'b0, den};
      q_in    = q_ff;
      r_in    = r_ff;
      n_in    = n_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = {num, 16'd0};
         r_in    = '0;
         n_in    = 5'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[8]) begin
            r_in = trial[7:0];
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[6:0], q_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         n_in = n_ff - 5'd1;
         if (n_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      n_ff <= n_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign done = busy_ff && n_ff == 5'd1;
   assign quo  = q_in[NW-1:FracBits];
   assign frac = q_in[FracBits-1:0];
endmodule

// ===== hdl/bus_cubic.sv =====
// bus_cubic: sequenced catmull-rom evaluation, one multiply per cycle
// depends on bus_pkg
module bus_cubic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  bus_pkg::coef_type                coef,
   input  logic [15:0]                      t,
   output logic                             done,
   output logic signed [bus_pkg::AccW-1:0]  result
);
   import bus_pkg::*;
   coef_type               k_ff;
   logic [1:0]             ph_ff, ph_in;
   logic                   act_ff, act_in;
   logic signed [AccW-1:0] acc_ff, acc_in, sh;
   logic signed [AccW-1:0] res_ff;
   logic signed [2*AccW-1:0] prod;

   always_comb begin
      prod   = $signed({1'b0, t}) * acc_ff;
      sh     = floor_shr(prod, (ph_ff == 2'd2) ? FracBits + 1 : FracBits);
      acc_in = acc_ff;
      ph_in  = ph_ff;
      act_in = act_ff;
      done   = 1'b0;
      if (start) begin
         acc_in = coef.c;
         ph_in  = 2'd0;
         act_in = 1'b1;
      end else if (act_ff) begin
         case (ph_ff)
            2'd0: acc_in = k_ff.b + sh;
            2'd1: acc_in = k_ff.a + sh;
            default: begin
               acc_in = k_ff.q1 + sh;
               act_in = 1'b0;
               done   = 1'b1;
            end
         endcase
         ph_in = ph_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) k_ff <= coef;
      acc_ff <= acc_in;
      ph_ff  <= ph_in;
      if (done) res_ff <= acc_in;
      if (reset) act_ff <= 1'b0;
      else       act_ff <= act_in;
   end

   assign result = done ? acc_in : res_ff;
endmodule
